[hdl/plint_pkg.sv]
package plint_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = $clog2(3 * ValueWidth);
   localparam logic [CountWidth-1:0] DivLast = CountWidth'(3 * ValueWidth - 1);

   typedef enum logic [2:0] {
      STATUS_VALUE    = 3'd0,
      STATUS_NULL     = 3'd1,
      STATUS_BELOW    = 3'd2,
      STATUS_ABOVE    = 3'd3,
      STATUS_NOT_INCR = 3'd4,
      STATUS_FEW      = 3'd5,
      STATUS_Y_SHORT  = 3'd6,
      STATUS_NONE     = 3'd7
   } plint_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } plint_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic mul_load;
      logic div_init;
      logic div_step;
      logic out_status;
      logic out_value;
   } plint_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;
      logic interp;
   } plint_sts_type;

endpackage

[hdl/plint_ctrl.sv]
module plint_ctrl
   import plint_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  plint_sts_type sts,
   output plint_cmd_type cmd
);

   plint_state_type state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && sts.interp) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (count_ff == DivLast) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = !rsp_valid_ff || rsp_ready;
            cmd.accept     = req_valid && req_ready;
            cmd.out_status = cmd.accept && sts.emit && !sts.interp;
         end
         ST_MUL:  cmd.mul_load  = 1'b1;
         ST_LOAD: cmd.div_init  = 1'b1;
         ST_DIV:  cmd.div_step  = 1'b1;
         ST_DONE: cmd.out_value = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.div_init) count_in = '0;
      else if (cmd.div_step) count_in = count_ff + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_status || cmd.out_value) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/plint_div.sv]
module plint_div
   import plint_pkg::*;
(
   input  logic                    clock,
   input  logic                    init,
   input  logic                    step,
   input  logic [3*ValueWidth-1:0] dividend,
   input  logic [ValueWidth-1:0]   divisor,
   output logic [ValueWidth-1:0]   quotient
);

   logic [ValueWidth-1:0]   rem_ff, rem_in;
   logic [3*ValueWidth-1:0] quo_ff, quo_in;
   logic [ValueWidth:0]     shifted;
   logic [ValueWidth:0]     trial;

   // restoring division from a zero remainder, one quotient bit per step over
   // the whole dividend; only the low word of the quotient is used
   always_comb begin
      shifted = {rem_ff, quo_ff[3*ValueWidth-1]};
      trial   = shifted - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (init) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (step) begin
         if (!trial[ValueWidth]) begin
            rem_in = trial[ValueWidth-1:0];
            quo_in = {quo_ff[3*ValueWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[ValueWidth-1:0];
            quo_in = {quo_ff[3*ValueWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff[ValueWidth-1:0];

endmodule

[hdl/plint_dp.sv]
module plint_dp
   import plint_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  plint_cmd_type                cmd,
   output plint_sts_type                sts,
   input  logic signed [ValueWidth-1:0] req_query_x,
   input  logic signed [ValueWidth-1:0] req_point_x,
   input  logic signed [ValueWidth-1:0] req_point_y,
   input  logic                         req_y_absent,
   input  logic                         req_row_null,
   input  logic                         req_row_last,
   output logic signed [ValueWidth-1:0] rsp_interp_y,
   output logic [2:0]                   rsp_status
);

   // row state
   logic signed [ValueWidth-1:0] prev_x_ff, prev_x_in;
   logic signed [ValueWidth-1:0] prev_y_ff, prev_y_in;
   logic [1:0] count_ff, count_in;
   logic answered_ff, answered_in;

   // interpolation operands
   logic [ValueWidth-1:0]          dx_ff, dy_ff;
   logic signed [ValueWidth:0]     dq_ff;
   logic                           up_ff;
   logic signed [ValueWidth-1:0]   base_ff;
   logic signed [2*ValueWidth+1:0] prod_ff;
   logic [3*ValueWidth-1:0]        numer;
   logic [ValueWidth-1:0]          quotient;

   // result register
   logic signed [ValueWidth-1:0] rsp_y_ff;
   plint_status_type             rsp_status_ff;

   plint_status_type st;
   logic first;
   logic up;
   logic [ValueWidth:0] diff_x, diff_q, diff_y_up, diff_y_dn;

   always_comb begin
      diff_x    = {req_point_x[ValueWidth-1], req_point_x}
                - {prev_x_ff[ValueWidth-1], prev_x_ff};
      diff_q    = {req_query_x[ValueWidth-1], req_query_x}
                - {prev_x_ff[ValueWidth-1], prev_x_ff};
      diff_y_up = {req_point_y[ValueWidth-1], req_point_y}
                - {prev_y_ff[ValueWidth-1], prev_y_ff};
      diff_y_dn = {prev_y_ff[ValueWidth-1], prev_y_ff}
                - {req_point_y[ValueWidth-1], req_point_y};
      up        = !(req_point_y < prev_y_ff);
      first     = (count_ff == 2'd0);
   end

   // classify the incoming transaction against the row state
   always_comb begin
      st = STATUS_NONE;
      if (req_row_null) begin
         st = STATUS_NULL;
      end else if (req_y_absent) begin
         st = STATUS_Y_SHORT;
      end else begin
         if (first) begin
            if (req_query_x < req_point_x) st = STATUS_BELOW;
         end else if (!(prev_x_ff < req_point_x)) begin
            st = STATUS_NOT_INCR;
         end else if (!(req_point_x < req_query_x)) begin
            st = STATUS_VALUE;
         end
         if (st == STATUS_NONE && req_row_last) begin
            st = first ? STATUS_FEW : STATUS_ABOVE;
         end
      end
      sts.emit   = !answered_ff && (st != STATUS_NONE);
      sts.interp = !answered_ff && (st == STATUS_VALUE);
   end

   always_comb begin
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      count_in    = count_ff;
      answered_in = answered_ff;
      if (cmd.accept) begin
         if (req_row_last) begin
            prev_x_in   = '0;
            prev_y_in   = '0;
            count_in    = 2'd0;
            answered_in = 1'b0;
         end else if (!answered_ff) begin
            if (!req_row_null && !req_y_absent) begin
               count_in = first ? 2'd1 : 2'd2;
            end
            if (st == STATUS_NONE) begin
               prev_x_in = req_point_x;
               prev_y_in = req_point_y;
            end else begin
               answered_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         count_ff    <= 2'd0;
         answered_ff <= 1'b0;
      end else begin
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
         count_ff    <= count_in;
         answered_ff <= answered_in;
      end
   end

   // capture operands of the bracketing segment; the query offset keeps its
   // sign, since a query that moves within a row can fall below prev_x
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dx_ff   <= diff_x[ValueWidth-1:0];
         dq_ff   <= diff_q;
         dy_ff   <= up ? diff_y_up[ValueWidth-1:0] : diff_y_dn[ValueWidth-1:0];
         up_ff   <= up;
         base_ff <= prev_y_ff;
      end
      if (cmd.mul_load) prod_ff <= $signed({1'b0, dy_ff}) * dq_ff;
   end

   // dividend is dy times the offset taken as a 64-bit two's complement
   // word: a negative offset adds dy at bit 64; add half the divisor for
   // round-to-nearest, ties away from zero
   assign numer = {dy_ff & {ValueWidth{dq_ff[ValueWidth]}}, {(2*ValueWidth){1'b0}}}
                + {{(ValueWidth-2){prod_ff[2*ValueWidth+1]}}, prod_ff}
                + {{(2*ValueWidth+1){1'b0}}, dx_ff[ValueWidth-1:1]};

   plint_div u_div (
      .clock    (clock),
      .init     (cmd.div_init),
      .step     (cmd.div_step),
      .dividend (numer),
      .divisor  (dx_ff),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_status) begin
         rsp_y_ff      <= '0;
         rsp_status_ff <= st;
      end else if (cmd.out_value) begin
         rsp_y_ff      <= up_ff ? base_ff + $signed(quotient) : base_ff - $signed(quotient);
         rsp_status_ff <= STATUS_VALUE;
      end
   end

   assign rsp_interp_y = rsp_y_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

[hdl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator. A row arrives as a run of request
// transactions, one breakpoint (point_x, point_y) each, in table order, with
// the query abscissa repeated on every one and row_last marking the final
// breakpoint. The block answers each row with exactly one response
// transaction: the interpolated ordinate (signed fixed point, rounded to
// nearest, ties away from zero) as soon as the segment holding the query is
// found, or a status code (null input, below range, above range, x not
// strictly increasing, fewer than two points, y table short). Requests of a
// row after its answer produce nothing; row_last always resets the row.
// Sequencing: a request that does not interpolate is handled in the idle
// state. A request that hits the bracketing segment occupies the block,
// which holds req_ready low, through acceptance, the 33x33 product, forming
// the rounded triple-width dividend, one step per dividend bit in the
// bit-serial restoring divider, and applying the sign and loading the
// response register. The divider walks the full dividend because a query
// that moves below the stored breakpoint within a row wraps the offset and
// pushes the dividend's high word past the divisor. The response sits in an
// output register; a new request is taken in the same cycle the waiting
// response is consumed.
module piecewise_linear_interpolator
   import plint_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ValueWidth-1:0] req_query_x,
   input  logic signed [ValueWidth-1:0] req_point_x,
   input  logic signed [ValueWidth-1:0] req_point_y,
   input  logic                         req_y_absent,
   input  logic                         req_row_null,
   input  logic                         req_row_last,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ValueWidth-1:0] rsp_interp_y,
   output logic [2:0]                   rsp_status
);

   plint_cmd_type cmd;
   plint_sts_type sts;

   // sequencer: accept, multiply, divide, load response
   plint_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // row state, segment test, multiplier, divider and response register
   plint_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_query_x  (req_query_x),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_y_absent (req_y_absent),
      .req_row_null (req_row_null),
      .req_row_last (req_row_last),
      .rsp_interp_y (rsp_interp_y),
      .rsp_status   (rsp_status)
   );

endmodule
